@@ hw/rtl/dbscan_pkg.sv @@
// Package for the DBSCAN point clustering block.
// Shared constants, register indexes and controller/datapath command types.
// No dependencies.
package dbscan_pkg;

	localparam int MAX_POINTS_DEF = 64;
	localparam int MAX_DIMS_DEF   = 8;

	// field widths fixed by the interface
	localparam int COORD_W = 16;
	localparam int DIMS_W  = 4;
	localparam int EPS_W   = 16;
	localparam int MINP_W  = 7;
	localparam int IDX_W   = 6;
	localparam int CID_W   = 6;
	localparam int CLUS_W  = 7;
	localparam int SQ_W    = 2 * EPS_W;

	// config register map (word index)
	localparam logic [1:0] REG_DIMS    = 2'd0;
	localparam logic [1:0] REG_EPS     = 2'd1;
	localparam logic [1:0] REG_MIN_PTS = 2'd2;

	localparam logic [DIMS_W-1:0] DIMS_RST    = 4'd2;
	localparam logic [EPS_W-1:0]  EPS_RST     = 16'd256;
	localparam logic [MINP_W-1:0] MIN_PTS_RST = 7'd4;

	typedef struct packed {
		logic load;
		logic n_clr;
		logic n_inc;
		logic i_clr;
		logic i_inc;
		logic j_clr;
		logic j_inc;
		logic d_clr;
		logic d_inc;
		logic sq;
		logic acc;
		logic row_clr;
		logic row_bit;
		logic row_wr;
		logic seed;
		logic pop;
		logic scan;
		logic clus_inc;
		logic emit;
		logic clr_set;
	} dbscan_cmd_t;

	typedef struct packed {
		logic n_more;
		logic n_zero;
		logic self;
		logic d_last;
		logic j_last;
		logic i_last;
		logic seed_ok;
		logic sp_zero;
	} dbscan_sts_t;

endpackage

@@ hw/rtl/dbscan_ctrl.sv @@
// Controller FSM for DBSCAN clustering: load, count, neighbor build,
// expansion and label output phases. Depends on dbscan_pkg.
module dbscan_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 last_of_set,
	input  dbscan_pkg::dbscan_sts_t sts,
	output dbscan_pkg::dbscan_cmd_t cmd,
	output logic                 busy
);

	localparam logic [4:0] ST_IDLE      = 5'd0;
	localparam logic [4:0] ST_NCNT      = 5'd1;
	localparam logic [4:0] ST_NB_INIT   = 5'd2;
	localparam logic [4:0] ST_ROW_INIT  = 5'd3;
	localparam logic [4:0] ST_PAIR_INIT = 5'd4;
	localparam logic [4:0] ST_RD        = 5'd5;
	localparam logic [4:0] ST_SQ        = 5'd6;
	localparam logic [4:0] ST_ACC       = 5'd7;
	localparam logic [4:0] ST_PAIR_NEXT = 5'd8;
	localparam logic [4:0] ST_ROW_END   = 5'd9;
	localparam logic [4:0] ST_EXP_I     = 5'd10;
	localparam logic [4:0] ST_POP_RD    = 5'd11;
	localparam logic [4:0] ST_POP_WT    = 5'd12;
	localparam logic [4:0] ST_SCAN      = 5'd13;
	localparam logic [4:0] ST_OUT_RD    = 5'd14;
	localparam logic [4:0] ST_OUT_EM    = 5'd15;
	localparam logic [4:0] ST_FIN       = 5'd16;

	logic [4:0] state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					if (last_of_set) begin
						cmd.n_clr = 1'b1;
						state_d   = ST_NCNT;
					end
				end
			end
			ST_NCNT: begin
				if (sts.n_more) begin
					cmd.n_inc = 1'b1;
				end else begin
					state_d = ST_NB_INIT;
				end
			end
			ST_NB_INIT: begin
				cmd.i_clr = 1'b1;
				state_d   = sts.n_zero ? ST_FIN : ST_ROW_INIT;
			end
			ST_ROW_INIT: begin
				cmd.j_clr   = 1'b1;
				cmd.row_clr = 1'b1;
				state_d     = ST_PAIR_INIT;
			end
			ST_PAIR_INIT: begin
				cmd.d_clr = 1'b1;
				state_d   = sts.self ? ST_PAIR_NEXT : ST_RD;
			end
			ST_RD: begin
				state_d = ST_SQ;
			end
			ST_SQ: begin
				cmd.sq  = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc   = 1'b1;
				cmd.d_inc = 1'b1;
				state_d   = sts.d_last ? ST_PAIR_NEXT : ST_RD;
			end
			ST_PAIR_NEXT: begin
				cmd.row_bit = 1'b1;
				cmd.j_inc   = 1'b1;
				state_d     = sts.j_last ? ST_ROW_END : ST_PAIR_INIT;
			end
			ST_ROW_END: begin
				cmd.row_wr = 1'b1;
				if (sts.i_last) begin
					cmd.i_clr = 1'b1;
					state_d   = ST_EXP_I;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = ST_ROW_INIT;
				end
			end
			ST_EXP_I: begin
				if (sts.seed_ok) begin
					cmd.seed = 1'b1;
					state_d  = ST_POP_RD;
				end else if (sts.i_last) begin
					cmd.i_clr = 1'b1;
					state_d   = ST_OUT_RD;
				end else begin
					cmd.i_inc = 1'b1;
				end
			end
			ST_POP_RD: begin
				if (sts.sp_zero) begin
					cmd.clus_inc = 1'b1;
					if (sts.i_last) begin
						cmd.i_clr = 1'b1;
						state_d   = ST_OUT_RD;
					end else begin
						cmd.i_inc = 1'b1;
						state_d   = ST_EXP_I;
					end
				end else begin
					cmd.pop   = 1'b1;
					cmd.j_clr = 1'b1;
					state_d   = ST_POP_WT;
				end
			end
			ST_POP_WT: begin
				state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan  = 1'b1;
				cmd.j_inc = 1'b1;
				if (sts.j_last) begin
					state_d = ST_POP_RD;
				end
			end
			ST_OUT_RD: begin
				state_d = ST_OUT_EM;
			end
			ST_OUT_EM: begin
				cmd.emit = 1'b1;
				if (sts.i_last) begin
					state_d = ST_FIN;
				end else begin
					cmd.i_inc = 1'b1;
					state_d   = ST_OUT_RD;
				end
			end
			ST_FIN: begin
				cmd.clr_set = 1'b1;
				state_d     = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/dbscan_dp.sv @@
// Datapath for DBSCAN clustering: coordinate, neighbor, label and stack
// memories, loop counters, distance unit and result register. Uses dbscan_pkg.
module dbscan_dp #(
	parameter int MAX_POINTS = dbscan_pkg::MAX_POINTS_DEF,
	parameter int MAX_DIMS   = dbscan_pkg::MAX_DIMS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  dbscan_pkg::dbscan_cmd_t             cmd,
	output dbscan_pkg::dbscan_sts_t             sts,
	input  logic signed [dbscan_pkg::COORD_W-1:0] coord,
	input  logic [dbscan_pkg::DIMS_W-1:0]       dims,
	input  logic [dbscan_pkg::EPS_W-1:0]        eps_radius,
	input  logic [dbscan_pkg::MINP_W-1:0]       min_pts,
	output logic                                result_valid,
	output logic [dbscan_pkg::IDX_W-1:0]        point_index,
	output logic [dbscan_pkg::CID_W-1:0]        cluster_id,
	output logic                                is_noise,
	output logic                                last_result,
	output logic                                truncated
);

	localparam int P_W    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PC_W   = $clog2(MAX_POINTS + 1);
	localparam int ND_W   = $clog2(MAX_DIMS + 1);
	localparam int CAP    = MAX_POINTS * MAX_DIMS;
	localparam int CA_W   = (CAP > 1) ? $clog2(CAP) : 1;
	localparam int CNT_W  = $clog2(CAP + 1);
	localparam int NP_W   = PC_W + ND_W + 1;
	localparam int AD_W   = P_W + ND_W + 1;
	localparam int SUM_W  = dbscan_pkg::SQ_W + ND_W;
	localparam int DIFF_W = dbscan_pkg::COORD_W + 1;

	// ---- effective dims ----
	logic [ND_W-1:0] nd;
	always_comb begin
		if (dims == '0) begin
			nd = ND_W'(1);
		end else if (32'(dims) > MAX_DIMS) begin
			nd = ND_W'(MAX_DIMS);
		end else begin
			nd = ND_W'(dims);
		end
	end

	// ---- load state ----
	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [NP_W-1:0]  cap_now;
	assign cap_now = NP_W'(MAX_POINTS) * NP_W'(nd);

	logic signed [dbscan_pkg::COORD_W-1:0] cmem [CAP];
	logic signed [dbscan_pkg::COORD_W-1:0] ca_q, cb_q;

	// ---- counters ----
	logic [PC_W-1:0] n_q;
	logic [P_W-1:0]  i_q, j_q;
	logic [ND_W-1:0] d_q;
	logic [NP_W-1:0] n_prod;
	assign n_prod = NP_W'(NP_W'(n_q) + NP_W'(1)) * NP_W'(nd);

	logic [AD_W-1:0] addr_a, addr_b;
	assign addr_a = AD_W'(AD_W'(i_q) * AD_W'(nd)) + AD_W'(d_q);
	assign addr_b = AD_W'(AD_W'(j_q) * AD_W'(nd)) + AD_W'(d_q);

	always_ff @(posedge clk) begin
		if (cmd.load && (NP_W'(cnt_q) < cap_now)) begin
			cmem[cnt_q[CA_W-1:0]] <= coord;
		end
		ca_q <= cmem[addr_a[CA_W-1:0]];
		cb_q <= cmem[addr_b[CA_W-1:0]];
	end

	// ---- distance unit ----
	logic signed [DIFF_W-1:0] diff;
	logic [DIFF_W-1:0]        mag;
	logic                     far_now;
	logic                     far_q;
	logic [dbscan_pkg::SQ_W-1:0] sq_q, eps_sq_q;
	logic [SUM_W-1:0]         sum_q;
	assign diff    = DIFF_W'(ca_q) - DIFF_W'(cb_q);
	assign mag     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign far_now = mag > DIFF_W'(eps_radius);

	always_ff @(posedge clk) begin
		eps_sq_q <= eps_radius * eps_radius;
		if (cmd.sq) begin
			sq_q <= far_now ? '0
				: (mag[dbscan_pkg::EPS_W-1:0] * mag[dbscan_pkg::EPS_W-1:0]);
		end
	end

	// ---- neighbor rows, core flags, labels, stack ----
	logic [MAX_POINTS-1:0] row_q;
	logic [PC_W-1:0]       rc_q;
	logic [MAX_POINTS-1:0] nm [MAX_POINTS];
	logic [MAX_POINTS-1:0] nm_rd_q;
	logic [MAX_POINTS-1:0] core_q;
	logic [MAX_POINTS-1:0] lab_v_q;
	logic [dbscan_pkg::CID_W-1:0] lab [MAX_POINTS];
	logic [dbscan_pkg::CID_W-1:0] lab_rd_q;
	logic [P_W-1:0]        stk [MAX_POINTS];
	logic [P_W-1:0]        stk_rd_q;
	logic [PC_W-1:0]       sp_q;
	logic [dbscan_pkg::CLUS_W-1:0] clus_q;
	logic                  pair_hit;
	logic                  scan_hit;
	logic                  push;
	logic [P_W-1:0]        push_val;
	logic                  lab_we;
	logic [P_W-1:0]        lab_wa;

	assign pair_hit = (i_q != j_q) && !far_q && (sum_q <= SUM_W'(eps_sq_q));
	assign scan_hit = cmd.scan && nm_rd_q[j_q] && !lab_v_q[j_q];
	assign push     = (cmd.seed || (scan_hit && core_q[j_q]))
		&& (sp_q < PC_W'(MAX_POINTS));
	assign push_val = cmd.seed ? i_q : j_q;
	assign lab_we   = cmd.seed || scan_hit;
	assign lab_wa   = cmd.seed ? i_q : j_q;

	always_ff @(posedge clk) begin
		if (cmd.row_wr) begin
			nm[i_q] <= row_q;
		end
		nm_rd_q <= nm[stk_rd_q];
		if (lab_we) begin
			lab[lab_wa] <= clus_q[dbscan_pkg::CID_W-1:0];
		end
		lab_rd_q <= lab[i_q];
		if (push) begin
			stk[sp_q[P_W-1:0]] <= push_val;
		end
		if (cmd.pop) begin
			stk_rd_q <= stk[P_W'(sp_q - PC_W'(1))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			ovf_q        <= 1'b0;
			n_q          <= '0;
			i_q          <= '0;
			j_q          <= '0;
			d_q          <= '0;
			far_q        <= 1'b0;
			sum_q        <= '0;
			row_q        <= '0;
			rc_q         <= '0;
			core_q       <= '0;
			lab_v_q      <= '0;
			sp_q         <= '0;
			clus_q       <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cmd.load) begin
				if (NP_W'(cnt_q) < cap_now) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
			if (cmd.n_clr) begin
				n_q <= '0;
			end else if (cmd.n_inc) begin
				n_q <= n_q + PC_W'(1);
			end
			if (cmd.i_clr) begin
				i_q <= '0;
			end else if (cmd.i_inc) begin
				i_q <= i_q + P_W'(1);
			end
			if (cmd.j_clr) begin
				j_q <= '0;
			end else if (cmd.j_inc) begin
				j_q <= j_q + P_W'(1);
			end
			if (cmd.d_clr) begin
				d_q   <= '0;
				far_q <= 1'b0;
				sum_q <= '0;
			end else begin
				if (cmd.sq && far_now) begin
					far_q <= 1'b1;
				end
				if (cmd.acc) begin
					sum_q <= sum_q + SUM_W'(sq_q);
				end
				if (cmd.d_inc) begin
					d_q <= d_q + ND_W'(1);
				end
			end
			if (cmd.row_clr) begin
				row_q <= '0;
				rc_q  <= '0;
			end else if (cmd.row_bit && pair_hit) begin
				row_q[j_q] <= 1'b1;
				rc_q       <= rc_q + PC_W'(1);
			end
			if (cmd.row_wr) begin
				core_q[i_q] <= (dbscan_pkg::MINP_W'(rc_q) >= min_pts);
			end
			if (lab_we) begin
				lab_v_q[lab_wa] <= 1'b1;
			end
			if (push) begin
				sp_q <= sp_q + PC_W'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_q - PC_W'(1);
			end
			if (cmd.clus_inc) begin
				clus_q <= clus_q + dbscan_pkg::CLUS_W'(1);
			end
			result_valid <= cmd.emit;
			if (cmd.clr_set) begin
				cnt_q   <= '0;
				ovf_q   <= 1'b0;
				clus_q  <= '0;
				core_q  <= '0;
				lab_v_q <= '0;
			end
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			point_index <= dbscan_pkg::IDX_W'(i_q);
			cluster_id  <= lab_v_q[i_q] ? lab_rd_q : '0;
			is_noise    <= !lab_v_q[i_q];
			last_result <= sts.i_last;
			truncated   <= ovf_q;
		end
	end

	// ---- status ----
	always_comb begin
		sts         = '0;
		sts.n_more  = (n_prod <= NP_W'(cnt_q)) && (n_q < PC_W'(MAX_POINTS));
		sts.n_zero  = (n_q == '0);
		sts.self    = (i_q == j_q);
		sts.d_last  = (d_q == nd - ND_W'(1));
		sts.j_last  = (PC_W'(j_q) == n_q - PC_W'(1));
		sts.i_last  = (PC_W'(i_q) == n_q - PC_W'(1));
		sts.seed_ok = !lab_v_q[i_q] && core_q[i_q];
		sts.sp_zero = (sp_q == '0);
	end

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= PC_W'(MAX_POINTS))
		else $error("expansion stack overrun");
	a_seed_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.seed |-> sp_q == '0)
		else $error("new cluster seeded with stack not empty");
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last_result |=> !result_valid)
		else $error("label word after final label");

endmodule

@@ hw/rtl/dbscan_point_clustering.sv @@
// Top level of the DBSCAN point clustering block: APB register file,
// controller and datapath. Depends on dbscan_pkg, dbscan_ctrl, dbscan_dp.
//
//  channel   | handshake                      | words
//  ----------+--------------------------------+----------------------------------
//  input     | start && !busy accepts         | coord, last_of_set
//  result    | result_valid, one cycle        | point_index, cluster_id, is_noise,
//            |                                | last_result, truncated
//  config    | psel&penable&pwrite&pready     | dims @0x0, eps_radius @0x4,
//            |                                | min_pts @0x8
//
// Loading accepts one coordinate word per cycle; busy stays low while loading.
// The closing word starts clustering of n points at d dims: points are counted,
// the neighbor matrix is built one coordinate pair at a time through a single
// distance unit (read, square and accumulate states), clusters are expanded
// and labels are output; busy is high throughout.
// Reset clears control state and registers go to 2/256/4; no clearing pass.
// Result words cannot be stalled by the receiver.
module dbscan_point_clustering #(
	parameter int MAX_POINTS = dbscan_pkg::MAX_POINTS_DEF,
	parameter int MAX_DIMS   = dbscan_pkg::MAX_DIMS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic signed [dbscan_pkg::COORD_W-1:0] coord,
	input  logic                                  last_of_set,
	output logic                                  result_valid,
	output logic [dbscan_pkg::IDX_W-1:0]          point_index,
	output logic [dbscan_pkg::CID_W-1:0]          cluster_id,
	output logic                                  is_noise,
	output logic                                  last_result,
	output logic                                  truncated,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [3:0]                            paddr,
	input  logic [31:0]                           pwdata,
	output logic [31:0]                           prdata,
	output logic                                  pready
);

	logic [dbscan_pkg::DIMS_W-1:0] dims_q;
	logic [dbscan_pkg::EPS_W-1:0]  eps_q;
	logic [dbscan_pkg::MINP_W-1:0] minp_q;
	logic                          wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	// config registers; the user must write them only between sets, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= dbscan_pkg::DIMS_RST;
			eps_q  <= dbscan_pkg::EPS_RST;
			minp_q <= dbscan_pkg::MIN_PTS_RST;
		end else if (wr_en) begin
			case (paddr[3:2])
				dbscan_pkg::REG_DIMS:    dims_q <= pwdata[dbscan_pkg::DIMS_W-1:0];
				dbscan_pkg::REG_EPS:     eps_q  <= pwdata[dbscan_pkg::EPS_W-1:0];
				dbscan_pkg::REG_MIN_PTS: minp_q <= pwdata[dbscan_pkg::MINP_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			dbscan_pkg::REG_DIMS:    prdata = 32'(dims_q);
			dbscan_pkg::REG_EPS:     prdata = 32'(eps_q);
			dbscan_pkg::REG_MIN_PTS: prdata = 32'(minp_q);
			default:                 prdata = '0;
		endcase
	end

	dbscan_pkg::dbscan_cmd_t cmd;
	dbscan_pkg::dbscan_sts_t sts;

	dbscan_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.last_of_set (last_of_set),
		.sts         (sts),
		.cmd         (cmd),
		.busy        (busy)
	);

	dbscan_dp #(
		.MAX_POINTS (MAX_POINTS),
		.MAX_DIMS   (MAX_DIMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.coord        (coord),
		.dims         (dims_q),
		.eps_radius   (eps_q),
		.min_pts      (minp_q),
		.result_valid (result_valid),
		.point_index  (point_index),
		.cluster_id   (cluster_id),
		.is_noise     (is_noise),
		.last_result  (last_result),
		.truncated    (truncated)
	);

endmodule
